// ===== sv/gbm_pkg.sv =====
// Package: widths, constants, state codes and saturation helper for the bracket search.
`default_nettype none
package gbm_pkg;

  localparam int PT_W   = 32;   // Q16.16 point / cost width
  localparam int GL_W   = 27;   // growth limit width
  localparam int MUL_W  = 34;   // shared multiplier operand width
  localparam int WIDE_W = 2 * MUL_W;  // product and wide intermediate width
  localparam int NUM_W  = 65;   // parabola numerator width
  localparam int DEN_W  = 34;   // parabola denominator width
  localparam int CNT_W  = $clog2(NUM_W);
  localparam int FRAC_W = 16;

  localparam logic signed [MUL_W-1:0] GOLD_Q = MUL_W'(106039);

  localparam logic signed [WIDE_W-1:0] MAX32 = WIDE_W'(64'sd2147483647);
  localparam logic signed [WIDE_W-1:0] MIN32 = -WIDE_W'(64'sd2147483648);

  // Configuration register indexes
  localparam logic [1:0] REG_START_A = 2'd0;
  localparam logic [1:0] REG_START_B = 2'd1;
  localparam logic [1:0] REG_GROWTH  = 2'd2;

  // Search phase, as seen between items
  typedef enum logic [6:0] {
    PH_IDLE       = 7'b0000001,
    PH_WAIT_A     = 7'b0000010,
    PH_WAIT_B     = 7'b0000100,
    PH_WAIT_C     = 7'b0001000,
    PH_WAIT_PARAB = 7'b0010000,
    PH_WAIT_EXT   = 7'b0100000,
    PH_WAIT_SHIFT = 7'b1000000
  } phase_t;

  // Sequencer inside one item
  typedef enum logic [13:0] {
    SQ_IDLE     = 14'b00000000000001,
    SQ_EMIT     = 14'b00000000000010,
    SQ_GOLD_MUL = 14'b00000000000100,
    SQ_GOLD_ADD = 14'b00000000001000,
    SQ_LH       = 14'b00000000010000,
    SQ_M1       = 14'b00000000100000,
    SQ_M2       = 14'b00000001000000,
    SQ_M3       = 14'b00000010000000,
    SQ_M4       = 14'b00000100000000,
    SQ_M5       = 14'b00001000000000,
    SQ_M6       = 14'b00010000000000,
    SQ_DIVW     = 14'b00100000000000,
    SQ_DECIDE   = 14'b01000000000000,
    SQ_SPARE    = 14'b10000000000000
  } seq_t;

  typedef struct packed {
    logic                    sat;
    logic signed [PT_W-1:0]  val;
  } sat_t;

  // Clamp a wide value to 32 bits, flagging when it clips
  function automatic sat_t sat32(input logic signed [WIDE_W-1:0] v);
    sat_t r;
    if (v > MAX32) begin
      r.sat = 1'b1;
      r.val = 32'sh7fffffff;
    end else if (v < MIN32) begin
      r.sat = 1'b1;
      r.val = 32'sh80000000;
    end else begin
      r.sat = 1'b0;
      r.val = PT_W'(v);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/gbm_if.sv =====
// Interfaces: input item channel and result item channel.
`default_nettype none
interface gbm_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] cost_value;
  modport source (output valid, output kind, output cost_value, input ready);
  modport sink   (input valid, input kind, input cost_value, output ready);
endinterface

interface gbm_out_if;
  logic               valid;
  logic               ready;
  logic               is_final;
  logic signed [31:0] query_point;
  logic signed [31:0] bracket_first;
  logic signed [31:0] bracket_middle;
  logic signed [31:0] bracket_last;
  logic               saturated;
  modport source (output valid, output is_final, output query_point, output bracket_first,
                  output bracket_middle, output bracket_last, output saturated, input ready);
  modport sink   (input valid, input is_final, input query_point, input bracket_first,
                  input bracket_middle, input bracket_last, input saturated, output ready);
endinterface
`default_nettype wire

// ===== sv/golden_bracket_minimum_top.sv =====
// Top level: minimum bracketing sequencer with shared multiplier and divider.
//
//  channel | dir | payload                                             | handshake
//  in_ch   | in  | kind, cost_value                                    | valid/ready
//  out_ch  | out | is_final, query_point, bracket_first/middle/last,   | valid/ready
//          |     | saturated                                           |
//  cfg_*   | in  | cfg_index, cfg_wdata                                | cfg_we
//
// A start item or the first cost goes straight to emit; a golden step runs
// the multiply and add; a cost that closes the bracket at the loop head emits
// directly; a parabolic step runs setup states with the shared multiplier, the
// one-bit-per-cycle divider, then decide and emit, or falls back to a golden
// step. One item is in work at a time; in_ch.ready is high only while
// the sequencer is idle. A finished result waits in the output register, and
// the sequencer holds it back until that register is free.
// Synchronous active-low reset returns the search to idle with all points zero.
`default_nettype none
module golden_bracket_minimum_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  gbm_in_if.sink           in_ch,
  gbm_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);
  import gbm_pkg::*;

  // Configuration
  logic signed [PT_W-1:0] start_a_r, start_b_r;
  logic [GL_W-1:0]        growth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_a_r <= '0;
      start_b_r <= 32'sd65536;
      growth_r  <= GL_W'(6553600);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_A: start_a_r <= cfg_wdata;
        REG_START_B: start_b_r <= cfg_wdata;
        REG_GROWTH:  growth_r  <= cfg_wdata[GL_W-1:0];
        default: ;
      endcase
    end
  end

  // Search state
  seq_t   seq_r, seq_nxt;
  phase_t phase_r, phase_nxt;
  logic signed [PT_W-1:0] pa_r, pb_r, pc_r, pt_r, fa_r, fb_r, fc_r;
  logic signed [PT_W-1:0] pa_nxt, pb_nxt, pc_nxt, pt_nxt, fa_nxt, fb_nxt, fc_nxt;
  logic sat_r, sat_nxt, gold_c_r, gold_c_nxt, res_final_r, res_final_nxt;
  logic signed [PT_W-1:0] res_query_r, res_query_nxt;

  // Loop-head scratch
  logic signed [PT_W-1:0] dba_r, dbc_r, ebc_r, eba_r, r_r, q_r, ulim_r, u_r;
  logic signed [PT_W-1:0] dba_nxt, dbc_nxt, ebc_nxt, eba_nxt, r_nxt, q_nxt, ulim_nxt, u_nxt;
  logic signed [63:0]      t_r, t_nxt;
  logic signed [NUM_W-1:0] num_r, num_nxt;
  logic signed [DEN_W-1:0] den_r, den_nxt;

  // Output register
  logic out_valid_r, out_final_r, out_sat_r;
  logic signed [PT_W-1:0] out_query_r, out_first_r, out_mid_r, out_last_r;
  logic out_free;

  // Shared units
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [WIDE_W-1:0] prod, prod_sh;
  logic                     div_start, div_done;
  logic signed [NUM_W-1:0]  quot;

  gbm_mul u_mul (.clk(clk), .op_a(mul_a), .op_b(mul_b), .prod(prod));

  gbm_div u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .num(num_r), .den(den_r),
                 .done(div_done), .quot(quot));

  assign prod_sh  = prod >>> FRAC_W;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (seq_r == SQ_IDLE);

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (seq_r)
      SQ_GOLD_MUL: begin
        mul_a = gold_c_r ? (MUL_W'(pb_r) - MUL_W'(pa_r)) : (MUL_W'(pc_r) - MUL_W'(pb_r));
        mul_b = GOLD_Q;
      end
      SQ_M1: begin
        mul_a = MUL_W'(dba_r);
        mul_b = MUL_W'(ebc_r);
      end
      SQ_M2: begin
        mul_a = MUL_W'(dbc_r);
        mul_b = MUL_W'(eba_r);
      end
      SQ_M3: begin
        mul_a = MUL_W'(dba_r);
        mul_b = MUL_W'(r_r);
      end
      SQ_M4: begin
        mul_a = MUL_W'(dbc_r);
        mul_b = MUL_W'(q_r);
      end
      SQ_M5: begin
        mul_a = MUL_W'(pc_r) - MUL_W'(pb_r);
        mul_b = $signed({{(MUL_W-GL_W){1'b0}}, growth_r});
      end
      default: ;
    endcase
  end

  // Sequencer and datapath
  always_comb begin
    sat_t s0, s1, s2, s3;
    logic signed [PT_W:0] dd;
    logic signed [PT_W-1:0] v;
    logic c1, c2, c3;

    seq_nxt       = seq_r;
    phase_nxt     = phase_r;
    pa_nxt = pa_r; pb_nxt = pb_r; pc_nxt = pc_r; pt_nxt = pt_r;
    fa_nxt = fa_r; fb_nxt = fb_r; fc_nxt = fc_r;
    sat_nxt       = sat_r;
    gold_c_nxt    = gold_c_r;
    res_final_nxt = res_final_r;
    res_query_nxt = res_query_r;
    dba_nxt = dba_r; dbc_nxt = dbc_r; ebc_nxt = ebc_r; eba_nxt = eba_r;
    r_nxt = r_r; q_nxt = q_r; t_nxt = t_r; ulim_nxt = ulim_r; u_nxt = u_r;
    num_nxt = num_r; den_nxt = den_r;
    div_start = 1'b0;
    v  = in_ch.cost_value;
    s0 = '0; s1 = '0; s2 = '0; s3 = '0;
    dd = '0;
    c1 = 1'b0; c2 = 1'b0; c3 = 1'b0;

    case (seq_r)
      SQ_IDLE: begin
        if (in_ch.valid) begin
          sat_nxt       = 1'b0;
          res_final_nxt = 1'b0;
          seq_nxt       = SQ_EMIT;
          if (!in_ch.kind) begin
            pa_nxt = start_a_r; pb_nxt = start_b_r; pc_nxt = '0; pt_nxt = '0;
            fa_nxt = '0; fb_nxt = '0; fc_nxt = '0;
            phase_nxt     = PH_WAIT_A;
            res_query_nxt = start_a_r;
          end else begin
            case (phase_r)
              PH_WAIT_A: begin
                fa_nxt        = v;
                phase_nxt     = PH_WAIT_B;
                res_query_nxt = pb_r;
              end
              PH_WAIT_B: begin
                // Keep the lower cost in b
                if (v > fa_r) begin
                  pa_nxt = pb_r; pb_nxt = pa_r; fa_nxt = v; fb_nxt = fa_r;
                end else begin
                  fb_nxt = v;
                end
                phase_nxt  = PH_WAIT_C;
                gold_c_nxt = 1'b1;
                seq_nxt    = SQ_GOLD_MUL;
              end
              PH_WAIT_C: begin
                fc_nxt  = v;
                seq_nxt = SQ_LH;
              end
              PH_WAIT_PARAB: begin
                if (v < fc_r) begin
                  pa_nxt = pb_r; fa_nxt = fb_r; pb_nxt = pt_r; fb_nxt = v;
                  res_final_nxt = 1'b1;
                  phase_nxt     = PH_IDLE;
                end else if (v > fb_r) begin
                  pc_nxt = pt_r; fc_nxt = v;
                  res_final_nxt = 1'b1;
                  phase_nxt     = PH_IDLE;
                end else begin
                  gold_c_nxt = 1'b0;
                  phase_nxt  = PH_WAIT_SHIFT;
                  seq_nxt    = SQ_GOLD_MUL;
                end
              end
              PH_WAIT_EXT: begin
                if (v < fc_r) begin
                  pb_nxt = pc_r; fb_nxt = fc_r; pc_nxt = pt_r; fc_nxt = v;
                  gold_c_nxt = 1'b0;
                  phase_nxt  = PH_WAIT_SHIFT;
                  seq_nxt    = SQ_GOLD_MUL;
                end else begin
                  pa_nxt = pb_r; pb_nxt = pc_r; pc_nxt = pt_r;
                  fa_nxt = fb_r; fb_nxt = fc_r; fc_nxt = v;
                  seq_nxt = SQ_LH;
                end
              end
              PH_WAIT_SHIFT: begin
                pa_nxt = pb_r; pb_nxt = pc_r; pc_nxt = pt_r;
                fa_nxt = fb_r; fb_nxt = fc_r; fc_nxt = v;
                seq_nxt = SQ_LH;
              end
              default: begin
                // Cost with no search running: repeat the last bracket
                res_final_nxt = 1'b1;
                phase_nxt     = PH_IDLE;
              end
            endcase
          end
        end
      end

      SQ_EMIT: begin
        if (out_free) seq_nxt = SQ_IDLE;
      end

      SQ_GOLD_MUL: seq_nxt = SQ_GOLD_ADD;

      SQ_GOLD_ADD: begin
        s0 = sat32(WIDE_W'(gold_c_r ? pb_r : pc_r) + prod_sh);
        sat_nxt = sat_r | s0.sat;
        if (gold_c_r) pc_nxt = s0.val;
        else          pt_nxt = s0.val;
        res_query_nxt = s0.val;
        seq_nxt       = SQ_EMIT;
      end

      SQ_LH: begin
        if (fb_r > fc_r) begin
          s0 = sat32(WIDE_W'(pb_r) - WIDE_W'(pa_r));
          s1 = sat32(WIDE_W'(pb_r) - WIDE_W'(pc_r));
          s2 = sat32(WIDE_W'(fb_r) - WIDE_W'(fc_r));
          s3 = sat32(WIDE_W'(fb_r) - WIDE_W'(fa_r));
          dba_nxt = s0.val; dbc_nxt = s1.val; ebc_nxt = s2.val; eba_nxt = s3.val;
          sat_nxt = sat_r | s0.sat | s1.sat | s2.sat | s3.sat;
          seq_nxt = SQ_M1;
        end else begin
          res_final_nxt = 1'b1;
          phase_nxt     = PH_IDLE;
          seq_nxt       = SQ_EMIT;
        end
      end

      SQ_M1: seq_nxt = SQ_M2;

      SQ_M2: begin
        s0 = sat32(prod_sh);
        r_nxt   = s0.val;
        sat_nxt = sat_r | s0.sat;
        seq_nxt = SQ_M3;
      end

      SQ_M3: begin
        s0 = sat32(prod_sh);
        q_nxt   = s0.val;
        sat_nxt = sat_r | s0.sat;
        seq_nxt = SQ_M4;
      end

      SQ_M4: begin
        t_nxt   = 64'(prod);
        seq_nxt = SQ_M5;
      end

      SQ_M5: begin
        // Numerator exact; zero denominator becomes one LSB, then doubled
        num_nxt = NUM_W'(prod) - NUM_W'(t_r);
        dd      = (PT_W+1)'(q_r) - (PT_W+1)'(r_r);
        den_nxt = (dd == '0) ? DEN_W'(2) : {dd, 1'b0};
        seq_nxt = SQ_M6;
      end

      SQ_M6: begin
        s0 = sat32(WIDE_W'(pb_r) + prod_sh);
        ulim_nxt  = s0.val;
        sat_nxt   = sat_r | s0.sat;
        div_start = 1'b1;
        seq_nxt   = SQ_DIVW;
      end

      SQ_DIVW: begin
        if (div_done) begin
          s0 = sat32(WIDE_W'(pb_r) - WIDE_W'(quot));
          u_nxt   = s0.val;
          sat_nxt = sat_r | s0.sat;
          seq_nxt = SQ_DECIDE;
        end
      end

      SQ_DECIDE: begin
        c1 = (pb_r > u_r && u_r > pc_r) || (pb_r < u_r && u_r < pc_r);
        c2 = (pc_r > u_r && u_r > ulim_r) || (pc_r < u_r && u_r < ulim_r);
        c3 = (u_r == ulim_r) || (ulim_r == pc_r) ||
             (u_r > ulim_r && ulim_r > pc_r) || (u_r < ulim_r && ulim_r < pc_r);
        seq_nxt = SQ_EMIT;
        if (c1) begin
          pt_nxt = u_r; res_query_nxt = u_r; phase_nxt = PH_WAIT_PARAB;
        end else if (c2) begin
          pt_nxt = u_r; res_query_nxt = u_r; phase_nxt = PH_WAIT_EXT;
        end else if (c3) begin
          pt_nxt = ulim_r; res_query_nxt = ulim_r; phase_nxt = PH_WAIT_SHIFT;
        end else begin
          gold_c_nxt = 1'b0;
          phase_nxt  = PH_WAIT_SHIFT;
          seq_nxt    = SQ_GOLD_MUL;
        end
      end

      default: seq_nxt = SQ_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r   <= SQ_IDLE;
      phase_r <= PH_IDLE;
      pa_r <= '0; pb_r <= '0; pc_r <= '0; pt_r <= '0;
      fa_r <= '0; fb_r <= '0; fc_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      seq_r   <= seq_nxt;
      phase_r <= phase_nxt;
      pa_r <= pa_nxt; pb_r <= pb_nxt; pc_r <= pc_nxt; pt_r <= pt_nxt;
      fa_r <= fa_nxt; fb_r <= fb_nxt; fc_r <= fc_nxt;
      if (seq_r == SQ_EMIT && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready)            out_valid_r <= 1'b0;
    end
  end

  // Scratch and output payload
  always_ff @(posedge clk) begin
    sat_r       <= sat_nxt;
    gold_c_r    <= gold_c_nxt;
    res_final_r <= res_final_nxt;
    res_query_r <= res_query_nxt;
    dba_r <= dba_nxt; dbc_r <= dbc_nxt; ebc_r <= ebc_nxt; eba_r <= eba_nxt;
    r_r <= r_nxt; q_r <= q_nxt; t_r <= t_nxt;
    ulim_r <= ulim_nxt; u_r <= u_nxt;
    num_r <= num_nxt; den_r <= den_nxt;
    if (seq_r == SQ_EMIT && out_free) begin
      out_final_r <= res_final_r;
      out_sat_r   <= sat_r;
      out_query_r <= res_final_r ? '0 : res_query_r;
      out_first_r <= res_final_r ? pa_r : '0;
      out_mid_r   <= res_final_r ? pb_r : '0;
      out_last_r  <= res_final_r ? pc_r : '0;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.is_final       = out_final_r;
  assign out_ch.query_point    = out_query_r;
  assign out_ch.bracket_first  = out_first_r;
  assign out_ch.bracket_middle = out_mid_r;
  assign out_ch.bracket_last   = out_last_r;
  assign out_ch.saturated      = out_sat_r;
endmodule
`default_nettype wire

// ===== sv/gbm_mul.sv =====
// Shared signed multiplier with a registered product.
`default_nettype none
module gbm_mul (
  input  wire logic                               clk,
  input  wire logic signed [gbm_pkg::MUL_W-1:0]   op_a,
  input  wire logic signed [gbm_pkg::MUL_W-1:0]   op_b,
  output logic signed [gbm_pkg::WIDE_W-1:0]       prod
);
  import gbm_pkg::*;

  logic signed [WIDE_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= WIDE_W'(op_a) * WIDE_W'(op_b);
  end

  assign prod = prod_r;
endmodule
`default_nettype wire

// ===== sv/gbm_div.sv =====
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module gbm_div (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic signed [gbm_pkg::NUM_W-1:0]   num,
  input  wire logic signed [gbm_pkg::DEN_W-1:0]   den,
  output logic                                    done,
  output logic signed [gbm_pkg::NUM_W-1:0]        quot
);
  import gbm_pkg::*;

  logic             busy_r, done_r, neg_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r, dmag_r;
  logic [NUM_W-1:0] quo_r;

  logic [DEN_W:0]   trial;
  logic             fits;

  // Bring down the next dividend bit and try a subtract
  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, dmag_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: magnitudes in, quotient bits shift in from the right
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r  <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      dmag_r <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
      rem_r  <= '0;
      neg_r  <= num[NUM_W-1] ^ den[DEN_W-1];
    end else if (busy_r) begin
      rem_r <= fits ? DEN_W'(trial - {1'b0, dmag_r}) : DEN_W'(trial);
      quo_r <= {quo_r[NUM_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = neg_r ? -$signed(quo_r) : $signed(quo_r);
endmodule
`default_nettype wire
